/* rtl/drf_pkg.sv */
// Package for the deduplicating request FIFO.
// Holds the beat types, action codes, controller states and shared widths.
// No dependencies.
`timescale 1ns / 1ps

package drf_pkg;

  localparam int IdW          = 24;
  localparam int LimW         = 6;
  localparam int CntW         = 6;
  localparam int DepthDefault = 32;
  localparam int DataW        = 32;
  localparam int AddrW        = 3;

  localparam logic [LimW-1:0] LimitReset = LimW'(32);

  // Word index of the queue_limit register.
  localparam logic [0:0] RegQueueLimit = 1'b0;

  typedef enum logic [1:0] {
    ACT_ADD     = 2'd0,
    ACT_DISCARD = 2'd1,
    ACT_QUERY   = 2'd2,
    ACT_POP     = 2'd3
  } act_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_POP
  } state_e;

  typedef struct packed {
    act_e            action;
    logic [IdW-1:0]  request_id;
    logic [CntW-1:0] pop_count;
  } in_item_t;

  typedef struct packed {
    logic [IdW-1:0] out_id;
    logic           has_id;
    logic           was_pending;
    logic           last;
  } out_item_t;

  // Per-cell update control: load takes the key, shift takes the neighbor.
  typedef struct packed {
    logic shift;
    logic load;
  } cell_ctl_t;

endpackage

/* rtl/drf_cell.sv */
// One slot of the request queue: holds an ID, compares it against the key
// and passes the running match flag to the next cell. Depends on drf_pkg.
`timescale 1ns / 1ps

module drf_cell (
  input  logic                    clk_i,
  input  logic [drf_pkg::IdW-1:0] key_i,
  input  logic                    valid_i,
  input  logic                    seen_i,
  input  drf_pkg::cell_ctl_t      ctl_i,
  input  logic [drf_pkg::IdW-1:0] nbr_i,
  output logic [drf_pkg::IdW-1:0] data_o,
  output logic                    seen_o
);

  logic [drf_pkg::IdW-1:0] data_q, data_d;

  // Match seen at this cell or any older one.
  assign seen_o = seen_i | (valid_i & (data_q == key_i));
  assign data_o = data_q;

  always_comb begin
    data_d = data_q;
    priority if (ctl_i.load) begin
      data_d = key_i;
    end else if (ctl_i.shift) begin
      data_d = nbr_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

endmodule

/* rtl/dedup_request_fifo.sv */
// Top level of the deduplicating request FIFO: controller, config register,
// output register and the row of drf_cell slots. Depends on drf_pkg, drf_cell.
`timescale 1ns / 1ps

// Ordered queue of distinct request IDs kept in a row of DEPTH cells, oldest
// in cell 0. One item is handled at a time. Add, discard and query pass
// through ST_EXEC once accepted: every cell compares its ID to the key, the
// match flag ripples down the row and the cells shift or load in place; the
// single result lands in the output register. A pop emits one beat per
// removed ID (at least one), since each result is read from cell 0 while the
// whole row shifts one place toward it. While a finished beat waits under
// out_stall_i, the block holds back its next beat. No clearing pass follows
// reset; the block accepts items right away. queue_limit lives at address 0.
module dedup_request_fifo #(
  parameter int DEPTH = drf_pkg::DepthDefault
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  drf_pkg::in_item_t           in_data_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output drf_pkg::out_item_t          out_data_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [drf_pkg::AddrW-1:0]   paddr,
  input  logic [drf_pkg::DataW-1:0]   pwdata,
  output logic [drf_pkg::DataW-1:0]   prdata,
  output logic                        pready
);

  localparam int OccW = $clog2(DEPTH + 1);
  localparam int CmpW = (OccW > drf_pkg::LimW) ? OccW : drf_pkg::LimW;

  drf_pkg::state_e   state_q, state_d;
  drf_pkg::in_item_t item_q, item_d;
  logic [OccW-1:0]   occ_q, occ_d;
  logic [drf_pkg::CntW-1:0] rem_q, rem_d;
  logic [drf_pkg::LimW-1:0] limit_q;
  logic              out_valid_q, out_valid_d;
  drf_pkg::out_item_t out_q, out_d;

  logic [drf_pkg::IdW-1:0] cell_data [DEPTH];
  logic [DEPTH:0]          seen;
  drf_pkg::cell_ctl_t      ctl [DEPTH];

  logic            out_free, exec_go, pop_go, hit, drop, do_append, add_miss;
  logic [CmpW-1:0] lim_eff;
  logic [OccW-1:0] app_idx;

  // Configuration port.
  assign pready = 1'b1;
  assign prdata = drf_pkg::DataW'(limit_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= drf_pkg::LimitReset;
    end else if (psel && penable && pwrite && pready &&
                 paddr[drf_pkg::AddrW-1] == drf_pkg::RegQueueLimit) begin
      limit_q <= pwdata[drf_pkg::LimW-1:0];
    end
  end

  // Cell row.
  assign seen[0] = 1'b0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [drf_pkg::IdW-1:0] nbr;
    logic                    valid;

    if (i == DEPTH - 1) begin : g_tail
      assign nbr = '0;
    end else begin : g_body
      assign nbr = cell_data[i+1];
    end

    assign valid = OccW'(i) < occ_q;

    assign ctl[i].load  = exec_go && add_miss && do_append && (OccW'(i) == app_idx);
    assign ctl[i].shift = pop_go
                       || (exec_go && add_miss && drop && (OccW'(i) < app_idx))
                       || (exec_go && item_q.action == drf_pkg::ACT_DISCARD && seen[i+1]);

    drf_cell u_cell (
      .clk_i   (clk_i),
      .key_i   (item_q.request_id),
      .valid_i (valid),
      .seen_i  (seen[i]),
      .ctl_i   (ctl[i]),
      .nbr_i   (nbr),
      .data_o  (cell_data[i]),
      .seen_o  (seen[i+1])
    );
  end

  assign hit      = seen[DEPTH];
  assign add_miss = (item_q.action == drf_pkg::ACT_ADD) && !hit;
  assign lim_eff  = (CmpW'(limit_q) > CmpW'(DEPTH)) ? CmpW'(DEPTH) : CmpW'(limit_q);
  assign drop     = (CmpW'(occ_q) >= lim_eff) && (occ_q != '0);
  assign do_append = drop || (occ_q < OccW'(DEPTH));
  assign app_idx  = drop ? (occ_q - OccW'(1)) : occ_q;

  assign out_free = !out_valid_q || !out_stall_i;
  assign exec_go  = (state_q == drf_pkg::ST_EXEC) && out_free;
  assign pop_go   = (state_q == drf_pkg::ST_POP) && out_free &&
                    (rem_q != '0) && (occ_q != '0);

  assign in_stall_o  = (state_q != drf_pkg::ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_comb begin
    state_d     = state_q;
    item_d      = item_q;
    occ_d       = occ_q;
    rem_d       = rem_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;

    unique case (state_q)
      drf_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          item_d  = in_data_i;
          rem_d   = in_data_i.pop_count;
          state_d = (in_data_i.action == drf_pkg::ACT_POP) ? drf_pkg::ST_POP
                                                           : drf_pkg::ST_EXEC;
        end
      end
      drf_pkg::ST_EXEC: begin
        if (out_free) begin
          out_valid_d       = 1'b1;
          out_d.out_id      = '0;
          out_d.has_id      = 1'b0;
          out_d.was_pending = hit;
          out_d.last        = 1'b1;
          if (add_miss) begin
            occ_d = occ_q - OccW'(drop) + OccW'(do_append);
          end else if (item_q.action == drf_pkg::ACT_DISCARD && hit) begin
            occ_d = occ_q - OccW'(1);
          end
          state_d = drf_pkg::ST_IDLE;
        end
      end
      drf_pkg::ST_POP: begin
        if (out_free) begin
          out_valid_d       = 1'b1;
          out_d.was_pending = 1'b0;
          if (pop_go) begin
            out_d.out_id = cell_data[0];
            out_d.has_id = 1'b1;
            out_d.last   = (rem_q == drf_pkg::CntW'(1)) || (occ_q == OccW'(1));
            occ_d        = occ_q - OccW'(1);
            rem_d        = rem_q - drf_pkg::CntW'(1);
            if (out_d.last) begin
              state_d = drf_pkg::ST_IDLE;
            end
          end else begin
            // Nothing to remove: one empty closing beat.
            out_d.out_id = '0;
            out_d.has_id = 1'b0;
            out_d.last   = 1'b1;
            state_d      = drf_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_d = drf_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= drf_pkg::ST_IDLE;
      occ_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      occ_q       <= occ_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    rem_q  <= rem_d;
    out_q  <= out_d;
  end

  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= OccW'(DEPTH))
    else $error("occupancy above depth");

  a_occ_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> (occ_q == $past(occ_q)) || (occ_q == $past(occ_q) + OccW'(1)) ||
             (occ_q + OccW'(1) == $past(occ_q)))
    else $error("occupancy moved by more than one");

  a_empty_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.has_id || out_data_o.last))
    else $error("beat without ID is not the last one");

  a_stall_while_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.has_id && !out_data_o.last) |-> in_stall_o)
    else $error("input open in the middle of a pop");

endmodule

/* dv/tb_dedup_request_fifo.sv */
// Self-checking testbench for dedup_request_fifo: queue-based stimulus, a clocked
// driver and monitor, an internal predictor of the ID queue, and APB setup.
// Depends on drf_pkg and the dedup_request_fifo RTL.
`timescale 1ns / 1ps

module tb_dedup_request_fifo;

  localparam int DEPTH          = drf_pkg::DepthDefault;
  localparam int CYCLE_LIMIT    = 2000000;
  localparam int HOLDOFF_CYCLES = 300;
  localparam int SETTLE_CYCLES  = 6;
  localparam int MAX_PRINTS     = 40;
  localparam int POOL_MAX       = 64;
  localparam logic [drf_pkg::AddrW-1:0] LimitAddr =
    drf_pkg::AddrW'(4 * drf_pkg::RegQueueLimit);

  logic                      clk_i;
  logic                      rst_ni;
  logic                      in_valid_i;
  logic                      in_stall_o;
  drf_pkg::in_item_t         in_data_i;
  logic                      out_valid_o;
  logic                      out_stall_i;
  drf_pkg::out_item_t        out_data_o;
  logic                      psel;
  logic                      penable;
  logic                      pwrite;
  logic [drf_pkg::AddrW-1:0] paddr;
  logic [drf_pkg::DataW-1:0] pwdata;
  logic [drf_pkg::DataW-1:0] prdata;
  logic                      pready;

  dedup_request_fifo #(.DEPTH(DEPTH)) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  // Predictor state and scoreboard.
  logic [drf_pkg::IdW-1:0]  queued_ids[$];
  logic [drf_pkg::LimW-1:0] limit_shadow;
  drf_pkg::out_item_t       expected_beats[$];
  drf_pkg::in_item_t        pending_items[$];
  logic [drf_pkg::IdW-1:0]  id_pool[POOL_MAX];

  int  err_count     = 0;
  int  items_taken   = 0;
  int  beats_checked = 0;
  int  peak_depth    = 0;
  int  longest_pop   = 0;
  int  drops_seen    = 0;
  int  in_stall_hits = 0;
  int  cycle_count   = 0;
  int  gap_left      = 0;
  int  stall_left    = 0;
  int  holdoff_left  = 0;
  bit  holdoff_go    = 0;
  bit  holdoff_done  = 0;
  bit  calm          = 0;

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (err_count < MAX_PRINTS)
      $display("mismatch %s: got %0h, expected %0h (cycle %0d)", what, got, want,
               cycle_count);
    err_count++;
  endtask

  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Work out every beat one accepted item produces and update the shadow queue.
  function automatic void predict_beats(input drf_pkg::in_item_t it);
    drf_pkg::out_item_t beat;
    int                 hit;
    int                 take;
    int                 cap;
    hit = -1;
    if (it.action == drf_pkg::ACT_POP) begin
      take = (int'(it.pop_count) < queued_ids.size()) ? int'(it.pop_count)
                                                      : queued_ids.size();
      if (take > longest_pop) longest_pop = take;
      if (take == 0) begin
        beat = '0;
        beat.last = 1'b1;
        expected_beats.push_back(beat);
      end else begin
        for (int k = 0; k < take; k++) begin
          beat = '0;
          beat.out_id = queued_ids[0];
          queued_ids.delete(0);
          beat.has_id = 1'b1;
          beat.last   = (k == take - 1);
          expected_beats.push_back(beat);
        end
      end
    end else begin
      for (int k = 0; k < queued_ids.size(); k++) begin
        if (queued_ids[k] == it.request_id) begin
          hit = k;
          break;
        end
      end
      if (it.action == drf_pkg::ACT_ADD && hit < 0) begin
        // Limit zero behaves as one once something is queued; clamp to DEPTH.
        cap = (int'(limit_shadow) > DEPTH) ? DEPTH : int'(limit_shadow);
        if (queued_ids.size() >= cap && queued_ids.size() > 0) begin
          queued_ids.delete(0);
          drops_seen++;
        end
        if (queued_ids.size() < DEPTH) queued_ids.push_back(it.request_id);
      end else if (it.action == drf_pkg::ACT_DISCARD && hit >= 0) begin
        queued_ids.delete(hit);
      end
      beat = '0;
      beat.was_pending = (hit >= 0);
      beat.last        = 1'b1;
      expected_beats.push_back(beat);
    end
    if (queued_ids.size() > peak_depth) peak_depth = queued_ids.size();
  endfunction

  // Sender: present queued items, hold the beat while stalled, insert random idle gaps between items.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_data_i  <= '0;
    end else begin
      if (in_valid_i && in_stall_o) in_stall_hits++;
      if (in_valid_i && !in_stall_o) begin
        predict_beats(in_data_i);
        items_taken++;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (gap_left != 0) begin
          gap_left   <= gap_left - 1;
          in_valid_i <= 1'b0;
        end else if (pending_items.size() != 0) begin
          in_data_i  <= pending_items[0];
          pending_items.delete(0);
          in_valid_i <= 1'b1;
          gap_left   <= pick_gap();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Receiver: check each beat against the oldest expectation, stall at random.
  always @(posedge clk_i) begin : receive
    drf_pkg::out_item_t want;
    int                 nxt;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      beats_checked++;
      if (expected_beats.size() == 0) begin
        report_mismatch("unexpected beat", 32'(out_data_o.out_id), 32'd0);
      end else begin
        want = expected_beats[0];
        expected_beats.delete(0);
        if (out_data_o.out_id !== want.out_id)
          report_mismatch("out_id", 32'(out_data_o.out_id), 32'(want.out_id));
        if (out_data_o.has_id !== want.has_id)
          report_mismatch("has_id", 32'(out_data_o.has_id), 32'(want.has_id));
        if (out_data_o.was_pending !== want.was_pending)
          report_mismatch("was_pending", 32'(out_data_o.was_pending),
                          32'(want.was_pending));
        if (out_data_o.last !== want.last)
          report_mismatch("last", 32'(out_data_o.last), 32'(want.last));
      end
    end
    nxt = (stall_left != 0) ? stall_left - 1 : pick_gap();
    stall_left  <= nxt;
    out_stall_i <= rst_ni && ((holdoff_left != 0) || (nxt != 0));
  end

  // Long receiver hold-off, counted here so the sender keeps pushing meanwhile.
  always @(posedge clk_i) begin
    if (holdoff_go && !holdoff_done) begin
      holdoff_left <= HOLDOFF_CYCLES;
      holdoff_done <= 1'b1;
    end else if (holdoff_left != 0) begin
      holdoff_left <= holdoff_left - 1;
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("FAIL dedup_request_fifo");
      $finish;
    end
  end

  // Write queue_limit, then read it back.
  task automatic write_limit(input logic [drf_pkg::LimW-1:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= LimitAddr;
    pwdata  <= drf_pkg::DataW'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    limit_shadow = value;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== drf_pkg::DataW'(value))
      report_mismatch("queue_limit readback", prdata, 32'(value));
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic wait_idle();
    while (pending_items.size() != 0 || in_valid_i || expected_beats.size() != 0)
      @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  function automatic drf_pkg::in_item_t mk(input drf_pkg::act_e act,
                                           input logic [drf_pkg::IdW-1:0] id,
                                           input logic [drf_pkg::CntW-1:0] cnt);
    drf_pkg::in_item_t it;
    it.action     = act;
    it.request_id = id;
    it.pop_count  = cnt;
    return it;
  endfunction

  function automatic drf_pkg::in_item_t make_item(input int pop_pct, input int pool_n);
    drf_pkg::in_item_t it;
    int                r;
    it.pop_count = ($urandom_range(0, 9) == 0) ? drf_pkg::CntW'($urandom_range(0, 63))
                                               : drf_pkg::CntW'($urandom_range(0, 4));
    it.request_id = ($urandom_range(0, 9) < 7) ? id_pool[$urandom_range(0, pool_n - 1)]
                                               : drf_pkg::IdW'($urandom);
    if ($urandom_range(0, 99) < pop_pct) begin
      it.action = drf_pkg::ACT_POP;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 55)      it.action = drf_pkg::ACT_ADD;
      else if (r < 75) it.action = drf_pkg::ACT_DISCARD;
      else             it.action = drf_pkg::ACT_QUERY;
    end
    return it;
  endfunction

  task automatic run_random(input logic [drf_pkg::LimW-1:0] lim, input int pop_pct,
                            input int pool_n, input bit quiet, input bit squeeze);
    write_limit(lim);
    @(negedge clk_i);
    calm = quiet;
    for (int i = 0; i < pool_n; i++) id_pool[i] = drf_pkg::IdW'($urandom);
    if (squeeze) holdoff_go = 1'b1;
    repeat (40) pending_items.push_back(make_item(pop_pct, pool_n));
    wait_idle();
  endtask

  initial begin
    rst_ni     = 1'b0;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = '0;
    pwdata     = '0;
    limit_shadow = drf_pkg::LimitReset;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: fill past a small limit, duplicates, discard, query, pops.
    write_limit(drf_pkg::LimW'(4));
    @(negedge clk_i);
    pending_items.push_back(mk(drf_pkg::ACT_ADD, 24'h000000, '0));
    pending_items.push_back(mk(drf_pkg::ACT_ADD, 24'hFFFFFF, '0));
    pending_items.push_back(mk(drf_pkg::ACT_ADD, 24'h000000, '0));
    pending_items.push_back(mk(drf_pkg::ACT_ADD, 24'h000001, '0));
    pending_items.push_back(mk(drf_pkg::ACT_ADD, 24'h000002, '0));
    pending_items.push_back(mk(drf_pkg::ACT_ADD, 24'h000003, '0));
    pending_items.push_back(mk(drf_pkg::ACT_QUERY, 24'h000001, '0));
    pending_items.push_back(mk(drf_pkg::ACT_QUERY, 24'h000000, '0));
    pending_items.push_back(mk(drf_pkg::ACT_DISCARD, 24'h000002, '0));
    pending_items.push_back(mk(drf_pkg::ACT_DISCARD, 24'h123456, '0));
    pending_items.push_back(mk(drf_pkg::ACT_POP, 24'hABCDEF, 6'd0));
    pending_items.push_back(mk(drf_pkg::ACT_POP, 24'h000000, 6'd2));
    pending_items.push_back(mk(drf_pkg::ACT_POP, 24'hFFFFFF, 6'd63));
    pending_items.push_back(mk(drf_pkg::ACT_POP, 24'h000000, 6'd1));
    wait_idle();

    // Lower the limit below the occupancy: each new add drops one oldest.
    write_limit(drf_pkg::LimW'(8));
    @(negedge clk_i);
    for (int i = 0; i < 6; i++)
      pending_items.push_back(mk(drf_pkg::ACT_ADD, drf_pkg::IdW'(24'h5A0010 + i), '0));
    wait_idle();
    write_limit(drf_pkg::LimW'(2));
    @(negedge clk_i);
    pending_items.push_back(mk(drf_pkg::ACT_ADD, 24'h5A0020, '0));
    pending_items.push_back(mk(drf_pkg::ACT_ADD, 24'h5A0020, '0));
    pending_items.push_back(mk(drf_pkg::ACT_POP, 24'h000000, 6'd63));
    wait_idle();

    // Limit zero: an add into an empty queue still lands.
    write_limit(drf_pkg::LimW'(0));
    @(negedge clk_i);
    pending_items.push_back(mk(drf_pkg::ACT_ADD, 24'hA5A5A5, '0));
    pending_items.push_back(mk(drf_pkg::ACT_ADD, 24'h5A5A5A, '0));
    pending_items.push_back(mk(drf_pkg::ACT_POP, 24'h000000, 6'd63));
    wait_idle();

    // Random phases over several limits, first one under a long output hold-off.
    run_random(drf_pkg::LimW'(32), 20, 24, 1'b0, 1'b1);
    run_random(drf_pkg::LimW'(1),  20, 6,  1'b0, 1'b0);
    run_random(drf_pkg::LimW'(63), 5,  48, 1'b0, 1'b0);
    run_random(drf_pkg::LimW'(5),  25, 10, 1'b1, 1'b0);
    run_random(drf_pkg::LimW'(17), 15, 30, 1'b0, 1'b0);
    run_random(drf_pkg::LimW'(0),  25, 4,  1'b0, 1'b0);
    run_random(drf_pkg::LimW'(32), 10, 40, 1'b0, 1'b0);

    @(negedge clk_i);
    pending_items.push_back(mk(drf_pkg::ACT_POP, 24'h000000, 6'd63));
    wait_idle();

    $display("covered %0d items, %0d beats, peak depth %0d, longest pop %0d",
             items_taken, beats_checked, peak_depth, longest_pop);
    $display("oldest-entry drops %0d, input stall cycles %0d, errors %0d",
             drops_seen, in_stall_hits, err_count);
    if (err_count == 0) begin
      $display("PASS dedup_request_fifo");
    end else begin
      $display("FAIL dedup_request_fifo");
    end
    $finish;
  end

endmodule

/* dedup_request_fifo.f */
rtl/drf_pkg.sv
rtl/drf_cell.sv
rtl/dedup_request_fifo.sv
dv/tb_dedup_request_fifo.sv
